### sv/kvtcp_pkg.sv
// Shared widths and character constants for the key/value command parser.
`default_nettype none

package kvtcp_pkg;

  localparam int unsigned ChW  = 8;
  localparam int unsigned NumW = 16;
  localparam int unsigned CntW = 3;

  localparam logic [CntW-1:0] MaxDigits = 3'd5;

  localparam logic [ChW-1:0] CharNul   = 8'h00;
  localparam logic [ChW-1:0] CharTab   = 8'h09;
  localparam logic [ChW-1:0] CharCr    = 8'h0D;
  localparam logic [ChW-1:0] CharSpace = 8'h20;
  localparam logic [ChW-1:0] CharZero  = 8'h30;
  localparam logic [ChW-1:0] CharNine  = 8'h39;
  localparam logic [ChW-1:0] CharUpA   = 8'h41;
  localparam logic [ChW-1:0] CharUpZ   = 8'h5A;
  localparam logic [ChW-1:0] CharLoA   = 8'h61;
  localparam logic [ChW-1:0] CharLoZ   = 8'h7A;

endpackage

`default_nettype wire

### sv/kvtcp_if.sv
// Valid/ready channel interfaces for characters in and parse results out.
`default_nettype none

interface kvtcp_in_if;
  logic                       valid;
  logic                       ready;
  logic [kvtcp_pkg::ChW-1:0]  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface kvtcp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [kvtcp_pkg::ChW-1:0]   key_first;
  logic [kvtcp_pkg::ChW-1:0]   key_second;
  logic [kvtcp_pkg::NumW-1:0]  number;

  modport source (output valid, output ok, output key_first, output key_second,
                  output number, input ready);
  modport sink   (input valid, input ok, input key_first, input key_second,
                  input number, output ready);
endinterface

`default_nettype wire

### sv/key_value_threshold_command_parser_core.sv
// Key/value command line parser: one character per item, one result per line.
//
// Usage:
//   in_chan carries one character per item; a zero character ends the line.
//   out_chan carries one result per line: ok, two key letters and the value.
//   A valid line is optional spaces/tabs, two letters, one to five decimal
//   digits, then only spaces, tabs or carriage returns. On failure the key
//   and value fields are zero. The value wraps modulo 65536.
// Timing:
//   One character is taken every cycle while in_chan.ready is high. The result
//   appears on out_chan in the cycle after the end-of-line item is accepted.
//   The single result register holds a waiting result; in_chan.ready drops
//   only while that register is full and out_chan.ready is low, so a stalled
//   receiver blocks the next item until the result is taken.
// Reset:
//   rst_n is synchronous, active low; it returns the parser to the leading
//   whitespace phase and empties the result register.
`default_nettype none

module key_value_threshold_command_parser_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  kvtcp_in_if.sink    in_chan,
  kvtcp_out_if.source out_chan
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_LET2,
    PH_DIG1,
    PH_DIGS,
    PH_TRAIL,
    PH_FAIL
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [kvtcp_pkg::ChW-1:0]       letter_one_r, letter_one_nxt;
  logic [kvtcp_pkg::ChW-1:0]       letter_two_r, letter_two_nxt;
  logic [kvtcp_pkg::NumW-1:0]      accum_r, accum_nxt;
  logic [kvtcp_pkg::CntW-1:0]      digits_r, digits_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            ok_r, ok_nxt;
  logic [kvtcp_pkg::ChW-1:0]       key_first_r, key_first_nxt;
  logic [kvtcp_pkg::ChW-1:0]       key_second_r, key_second_nxt;
  logic [kvtcp_pkg::NumW-1:0]      number_r, number_nxt;

  logic                            accept;
  logic                            is_letter, is_digit, is_blank, is_trail;
  logic [kvtcp_pkg::ChW-1:0]       ch;
  logic [kvtcp_pkg::NumW-1:0]      accum_step;
  logic                            line_ok;

  assign ch       = in_chan.ch;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept   = in_chan.valid && in_chan.ready;

  assign is_letter = ((ch >= kvtcp_pkg::CharUpA) && (ch <= kvtcp_pkg::CharUpZ)) ||
                     ((ch >= kvtcp_pkg::CharLoA) && (ch <= kvtcp_pkg::CharLoZ));
  assign is_digit  = (ch >= kvtcp_pkg::CharZero) && (ch <= kvtcp_pkg::CharNine);
  assign is_blank  = (ch == kvtcp_pkg::CharSpace) || (ch == kvtcp_pkg::CharTab);
  assign is_trail  = is_blank || (ch == kvtcp_pkg::CharCr);

  // accum * 10 + digit, modulo 2^16
  assign accum_step = {accum_r[kvtcp_pkg::NumW-4:0], 3'b000} +
                      {accum_r[kvtcp_pkg::NumW-2:0], 1'b0} +
                      {{(kvtcp_pkg::NumW-4){1'b0}}, ch[3:0]};

  assign line_ok = (phase_r == PH_DIGS) || (phase_r == PH_TRAIL);

  always_comb begin
    phase_nxt      = phase_r;
    letter_one_nxt = letter_one_r;
    letter_two_nxt = letter_two_r;
    accum_nxt      = accum_r;
    digits_nxt     = digits_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    ok_nxt         = ok_r;
    key_first_nxt  = key_first_r;
    key_second_nxt = key_second_r;
    number_nxt     = number_r;

    if (accept) begin
      if (ch == kvtcp_pkg::CharNul) begin
        out_valid_nxt  = 1'b1;
        ok_nxt         = line_ok;
        key_first_nxt  = line_ok ? letter_one_r : '0;
        key_second_nxt = line_ok ? letter_two_r : '0;
        number_nxt     = line_ok ? accum_r : '0;
        phase_nxt      = PH_LEAD;
        letter_one_nxt = '0;
        letter_two_nxt = '0;
        accum_nxt      = '0;
        digits_nxt     = '0;
      end else begin
        unique case (phase_r)
          PH_LEAD: begin
            if (is_letter) begin
              letter_one_nxt = ch;
              phase_nxt      = PH_LET2;
            end else if (!is_blank) begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_LET2: begin
            if (is_letter) begin
              letter_two_nxt = ch;
              phase_nxt      = PH_DIG1;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_DIG1, PH_DIGS: begin
            if (is_digit) begin
              if (digits_r >= kvtcp_pkg::MaxDigits) begin
                digits_nxt = kvtcp_pkg::MaxDigits + 3'd1;
                phase_nxt  = PH_FAIL;
              end else begin
                digits_nxt = digits_r + 3'd1;
                accum_nxt  = accum_step;
                phase_nxt  = PH_DIGS;
              end
            end else if ((phase_r == PH_DIGS) && is_trail) begin
              phase_nxt = PH_TRAIL;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_TRAIL: begin
            if (!is_trail) begin
              phase_nxt = PH_FAIL;
            end
          end
          default: begin
            phase_nxt = PH_FAIL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      letter_one_r <= '0;
      letter_two_r <= '0;
      accum_r      <= '0;
      digits_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      letter_one_r <= letter_one_nxt;
      letter_two_r <= letter_two_nxt;
      accum_r      <= accum_nxt;
      digits_r     <= digits_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ok_r         <= ok_nxt;
    key_first_r  <= key_first_nxt;
    key_second_r <= key_second_nxt;
    number_r     <= number_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.ok         = ok_r;
  assign out_chan.key_first  = key_first_r;
  assign out_chan.key_second = key_second_r;
  assign out_chan.number     = number_r;

`ifndef SYNTHESIS
  a_eol_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ch == kvtcp_pkg::CharNul)) |=> out_valid_r)
    else $error("end-of-line item did not load a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ch != kvtcp_pkg::CharNul) && (!out_valid_r || out_chan.ready))
      |=> !out_valid_r)
    else $error("result appeared without an end-of-line item");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ok_r) |->
      ((key_first_r == '0) && (key_second_r == '0) && (number_r == '0)))
    else $error("failed line carries nonzero fields");

  a_ok_has_letters: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ok_r) |->
      ((key_first_r != '0) && (key_second_r != '0)))
    else $error("successful line without key letters");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_DIGS) || (phase_r == PH_TRAIL)) |->
      ((digits_r != '0) && (digits_r <= kvtcp_pkg::MaxDigits)))
    else $error("digit count out of range in a passing phase");
`endif

endmodule

`default_nettype wire
